>>> hw/rtl/lgs_pkg.sv
// life generation stencil: shared types, constants and helper functions
// no dependencies; used by every module of the block
package lgs_pkg;

    // configuration register widths and indexes
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_BOARD_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_COLS = 1'd1;

    // smallest board that has an interior cell
    localparam logic [CFG_W-1:0] MIN_SIZE = 11'd3;

    // reported coordinate width
    localparam int unsigned POS_OUT_W = 10;

    // one line store entry: {row two above, row above}
    localparam int unsigned LINE_W = 2;

    // effective board size after clamping
    typedef struct packed {
        logic [CFG_W-1:0] rows;
        logic [CFG_W-1:0] cols;
    } board_size_t;

    // clamp a written size into 3 .. hi
    function automatic logic [CFG_W-1:0] clamp_size(logic [CFG_W-1:0] v, int unsigned hi);
        logic [CFG_W-1:0] res;
        res = v;
        if (v < MIN_SIZE)
        begin
            res = MIN_SIZE;
        end
        else if (32'(v) > hi)
        begin
            res = CFG_W'(hi);
        end
        return res;
    endfunction

    // b3/s23 rule on the eight-neighbour count
    function automatic logic life_rule(logic centre, logic [3:0] count);
        logic res;
        if (centre)
        begin
            res = (count == 4'd2) || (count == 4'd3);
        end
        else
        begin
            res = (count == 4'd3);
        end
        return res;
    endfunction

endpackage

>>> hw/rtl/life_generation_stencil.sv
// life generation stencil: top level, raster position and pipeline control
// depends on lgs_pkg, lgs_cfg, lgs_line_store and lgs_cell_eval
//
// Computes one b3/s23 generation of a board streamed in raster order, one
// cell per item, border cells included. The block takes one item every clock
// cycle for as long as the result side keeps up; the figure is set by the
// single line store memory, which is read once per item at the incoming
// column and written back as the item leaves stage one. An interior cell (r, c)
// is reported once cell (r+1, c+1) has been taken; its result is registered
// when that item leaves stage one. Border cells give no result. Writing
// board_rows or board_cols restarts the scan at row 0, column 0; sizes below 3
// act as 3 and sizes above MAX_ROWS or MAX_COLS act as those limits. After the
// last cell of the board the scan wraps and the next pass begins. There is no
// clearing pass after reset: the first two rows of every pass refill the line
// store before any result reads it.
module life_generation_stencil #(
    parameter int unsigned MAX_COLS = 1024,
    parameter int unsigned MAX_ROWS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]        cfg_data,
    // cell items in
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             cell_alive,
    // result items out
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             next_alive,
    output logic [lgs_pkg::POS_OUT_W-1:0]    cell_row,
    output logic [lgs_pkg::POS_OUT_W-1:0]    cell_col,
    output logic                             last_cell
);

    // the size registers are 11 bits, so a row count never exceeds 2047
    localparam int unsigned ROW_LIM = (MAX_ROWS > 2048) ? 2048 : MAX_ROWS;
    localparam int unsigned ROW_W   = $clog2(ROW_LIM);
    localparam int unsigned COL_W   = $clog2(MAX_COLS);

    lgs_pkg::board_size_t size;
    logic                 restart;

    // raster position of the next item to be taken
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;

    // stage one: line store read in flight for this item
    logic             s1_valid_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_bot_reg;

    logic                        accept;
    logic                        advance;
    logic [lgs_pkg::LINE_W-1:0]  line_data;
    logic [2:0]                  column;

    lgs_cfg #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .size      (size),
        .restart   (restart)
    );

    // stall only when stage one is full and cannot move on
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // advance the raster position, wrapping at the end of row and board
    assign col_inc = {1'b0, col_reg} + (COL_W + 1)'(1);
    assign row_inc = {1'b0, row_reg} + (ROW_W + 1)'(1);

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (32'(col_inc) >= 32'(size.cols))
            begin
                col_next = '0;
                if (32'(row_inc) >= 32'(size.rows))
                begin
                    row_next = '0;
                end
                else
                begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_row_reg <= row_reg;
            s1_col_reg <= col_reg;
            s1_bot_reg <= cell_alive;
        end
    end

    // line store: bit 1 is the row two above, bit 0 the row above.
    // the read for an item is at column c while the write-back of the item
    // ahead of it goes to a different column, so no forwarding is needed
    lgs_line_store #(
        .DEPTH (MAX_COLS),
        .AW    (COL_W)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (line_data),
        .wr_en   (advance),
        .wr_addr (s1_col_reg),
        .wr_data ({line_data[0], s1_bot_reg})
    );

    // column of three: top, middle, bottom (the incoming cell)
    assign column = {s1_bot_reg, line_data[0], line_data[1]};

    lgs_cell_eval #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_cell_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid_reg),
        .s1_row     (s1_row_reg),
        .s1_col     (s1_col_reg),
        .column     (column),
        .size       (size),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .next_alive (next_alive),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .last_cell  (last_cell)
    );

`ifndef SYNTH
    // raster position always lies inside the configured board
    a_row_in_board: assert property (@(posedge clk) disable iff (!rst_n)
        32'(row_reg) < 32'(size.rows))
        else $error("row position outside board");

    a_col_in_board: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(size.cols))
        else $error("column position outside board");

    // a read never hits the column being written back in the same cycle
    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && advance) |-> (col_reg != s1_col_reg))
        else $error("line store read and write at the same column");

    // the input side stalls only behind a held stage one
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid && out_stall))
        else $error("stall without a blocked result");

    // an interior item leaving stage one shows up as a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (32'(s1_row_reg) >= 32'd2) && (32'(s1_col_reg) >= 32'd2))
        |=> out_valid)
        else $error("interior cell lost");
`endif

endmodule

>>> hw/rtl/lgs_cfg.sv
// life generation stencil: board size registers with clamping
// depends on lgs_pkg
module lgs_cfg #(
    parameter int unsigned MAX_ROWS = 1024,
    parameter int unsigned MAX_COLS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]      cfg_data,
    output lgs_pkg::board_size_t           size,
    output logic                           restart
);

    localparam logic [lgs_pkg::CFG_W-1:0] ROWS_RST =
        (MAX_ROWS < 1024) ? lgs_pkg::CFG_W'(MAX_ROWS) : 11'd1024;
    localparam logic [lgs_pkg::CFG_W-1:0] COLS_RST =
        (MAX_COLS < 1024) ? lgs_pkg::CFG_W'(MAX_COLS) : 11'd1024;

    lgs_pkg::board_size_t size_reg;
    lgs_pkg::board_size_t size_next;

    always_comb
    begin
        size_next = size_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                lgs_pkg::REG_BOARD_ROWS:
                begin
                    size_next.rows = lgs_pkg::clamp_size(cfg_data, MAX_ROWS);
                end
                lgs_pkg::REG_BOARD_COLS:
                begin
                    size_next.cols = lgs_pkg::clamp_size(cfg_data, MAX_COLS);
                end
                default:
                begin
                    size_next = size_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg.rows <= ROWS_RST;
            size_reg.cols <= COLS_RST;
        end
        else
        begin
            size_reg <= size_next;
        end
    end

    assign size    = size_reg;
    // any register write restarts the raster scan
    assign restart = cfg_we;

endmodule

>>> hw/rtl/lgs_line_store.sv
// life generation stencil: line store memory, one entry per board column
// depends on lgs_pkg; synchronous read with registered read data
module lgs_line_store #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned AW    = 10
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [lgs_pkg::LINE_W-1:0]  rd_data,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [lgs_pkg::LINE_W-1:0]  wr_data
);

    logic [lgs_pkg::LINE_W-1:0] mem [DEPTH];
    logic [lgs_pkg::LINE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/lgs_cell_eval.sv
// life generation stencil: neighbour window, b3/s23 rule and output register
// depends on lgs_pkg
module lgs_cell_eval #(
    parameter int unsigned ROW_W = 10,
    parameter int unsigned COL_W = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s1_valid,
    input  logic [ROW_W-1:0]                 s1_row,
    input  logic [COL_W-1:0]                 s1_col,
    input  logic [2:0]                       column,
    input  lgs_pkg::board_size_t             size,
    output logic                             advance,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             next_alive,
    output logic [lgs_pkg::POS_OUT_W-1:0]    cell_row,
    output logic [lgs_pkg::POS_OUT_W-1:0]    cell_col,
    output logic                             last_cell
);

    // bits 2:0 column c-1 (bottom, middle, top), bits 5:3 column c-2
    logic [5:0] window_reg;
    logic [5:0] window_next;

    logic       out_valid_reg;
    logic       out_free;
    logic       hit;
    logic       centre;
    logic [3:0] count;
    logic       alive;
    logic       last;
    logic [ROW_W-1:0] row_m1;
    logic [COL_W-1:0] col_m1;

    logic                            alive_reg;
    logic [lgs_pkg::POS_OUT_W-1:0]   row_reg;
    logic [lgs_pkg::POS_OUT_W-1:0]   col_reg;
    logic                            last_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid && out_free;

    // interior cell (r-1, c-1) is complete once (r, c) is here
    assign hit    = (32'(s1_row) >= 32'd2) && (32'(s1_col) >= 32'd2);
    assign centre = window_reg[1];
    assign count  = 4'(column[0]) + 4'(column[1]) + 4'(column[2])
                  + 4'(window_reg[0]) + 4'(window_reg[2])
                  + 4'(window_reg[3]) + 4'(window_reg[4]) + 4'(window_reg[5]);
    assign alive  = lgs_pkg::life_rule(centre, count);
    assign last   = (32'(s1_row) + 32'd1 == 32'(size.rows))
                 && (32'(s1_col) + 32'd1 == 32'(size.cols));
    assign row_m1 = s1_row - ROW_W'(1);
    assign col_m1 = s1_col - COL_W'(1);

    assign window_next = {window_reg[2:0], column};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                window_reg <= window_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid && hit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hit)
        begin
            alive_reg <= alive;
            row_reg   <= lgs_pkg::POS_OUT_W'(32'(row_m1));
            col_reg   <= lgs_pkg::POS_OUT_W'(32'(col_m1));
            last_reg  <= last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_alive = alive_reg;
    assign cell_row   = row_reg;
    assign cell_col   = col_reg;
    assign last_cell  = last_reg;

endmodule

>>> tb/testbench.sv
// testbench for life_generation_stencil: streams boards of random size and content
// and checks every reported cell against a b3/s23 stencil predictor kept here
// depends on lgs_pkg and life_generation_stencil
`timescale 1ns / 1ps

module testbench;

    // largest board edge the block is built for (default parameters)
    localparam int unsigned BOARD_MAX = 1024;
    // cycles to let the pipeline empty before a register write
    localparam int unsigned SETTLE_CYCLES = 8;
    // long receiver hold-off, started once enough results have come and the
    // sender still has a backlog to push into the block
    localparam int unsigned HOLD_AFTER = 150;
    localparam int unsigned HOLD_CYCLES = 250;
    localparam int unsigned HOLD_BACKLOG = 16;
    // cycles with no handshake at all before the run is abandoned
    localparam int unsigned QUIET_LIMIT = 2000;
    // how many random cells on small boards
    localparam int unsigned RANDOM_TOTAL = 1100;

    // one reported interior cell
    typedef struct packed {
        logic                          alive;
        logic [lgs_pkg::POS_OUT_W-1:0] row;
        logic [lgs_pkg::POS_OUT_W-1:0] col;
        logic                          last;
    } cell_update_t;

    logic                          clk;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index = lgs_pkg::REG_BOARD_ROWS;
    logic [lgs_pkg::CFG_W-1:0]     cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic                          cell_alive = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          next_alive;
    logic [lgs_pkg::POS_OUT_W-1:0] cell_row;
    logic [lgs_pkg::POS_OUT_W-1:0] cell_col;
    logic                          last_cell;

    // cells waiting to be offered, and cell updates waiting to come out
    logic         cells_to_send [$];
    cell_update_t pending_updates [$];

    // predictor state: the two rows above the incoming one, the two columns to
    // the left of it (bits 0..2 column c-1 top to bottom, bits 3..5 column c-2),
    // the raster position and the sizes as written (before clamping)
    logic        line_above [BOARD_MAX] = '{default: 1'b0};
    logic        line_two_above [BOARD_MAX] = '{default: 1'b0};
    logic [5:0]  window_bits = '0;
    int unsigned scan_row = 0;
    int unsigned scan_col = 0;
    logic [lgs_pkg::CFG_W-1:0] size_rows = 11'd1024;
    logic [lgs_pkg::CFG_W-1:0] size_cols = 11'd1024;

    logic        in_took = 1'b0;
    int unsigned failures = 0;
    int unsigned results_seen = 0;
    int unsigned random_cells = 0;
    int unsigned quiet_cycles = 0;

    // sender and receiver pacing
    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned recv_stall_left = 0;
    int unsigned recv_calm = 0;
    bit          hold_done = 1'b0;

    life_generation_stencil i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cell_alive (cell_alive),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .next_alive (next_alive),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .last_cell  (last_cell)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // sizes below 3 behave as 3, sizes above the built maximum behave as the maximum
    function automatic int unsigned clamp_dim(logic [lgs_pkg::CFG_W-1:0] v);
        int unsigned res;
        res = 32'(v);
        if (res < 3)
        begin
            res = 3;
        end
        else if (res > BOARD_MAX)
        begin
            res = BOARD_MAX;
        end
        return res;
    endfunction

    // idle length for either side: mostly none or short, now and then long
    function automatic int unsigned pick_idle_length();
        int unsigned roll;
        int unsigned res;
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            res = 0;
        end
        else if (roll < 85)
        begin
            res = $urandom_range(1, 2);
        end
        else if (roll < 97)
        begin
            res = $urandom_range(3, 8);
        end
        else
        begin
            res = $urandom_range(20, 60);
        end
        return res;
    endfunction

    // a register write sets the size and restarts the scan; the line stores keep
    // their contents since the first two rows of a pass overwrite them anyway
    task automatic apply_size_write(input logic [lgs_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [lgs_pkg::CFG_W-1:0] value);
        if (idx == lgs_pkg::REG_BOARD_ROWS)
        begin
            size_rows = value;
        end
        else
        begin
            size_cols = value;
        end
        scan_row = 0;
        scan_col = 0;
    endtask

    // take one cell in raster order; once the cell below and to the right of an
    // interior cell has arrived, queue that interior cell's next state
    task automatic step_generation(input logic bottom);
        logic [2:0]   column;
        logic         centre;
        int unsigned  neighbours;
        int unsigned  rows_eff;
        int unsigned  cols_eff;
        cell_update_t upd;
        rows_eff = clamp_dim(size_rows);
        cols_eff = clamp_dim(size_cols);
        column = {bottom, line_above[scan_col], line_two_above[scan_col]};
        if (scan_row >= 2 && scan_col >= 2)
        begin
            centre = window_bits[1];
            // live border cells count like any other neighbour
            neighbours = $countones({column, window_bits}) - int'(centre);
            if (centre)
            begin
                upd.alive = (neighbours == 2) || (neighbours == 3);
            end
            else
            begin
                upd.alive = (neighbours == 3);
            end
            upd.row = lgs_pkg::POS_OUT_W'(scan_row - 1);
            upd.col = lgs_pkg::POS_OUT_W'(scan_col - 1);
            upd.last = (scan_row + 1 == rows_eff) && (scan_col + 1 == cols_eff);
            pending_updates.push_back(upd);
        end
        window_bits = {window_bits[2:0], column};
        line_two_above[scan_col] = line_above[scan_col];
        line_above[scan_col] = bottom;
        scan_col++;
        if (scan_col >= cols_eff)
        begin
            // end of row, and at the end of the board wrap into the next pass
            scan_col = 0;
            scan_row++;
            if (scan_row >= rows_eff)
            begin
                scan_row = 0;
            end
        end
    endtask

    // compare one accepted result with the oldest waiting update
    task automatic check_update();
        cell_update_t want;
        results_seen++;
        if (pending_updates.size() == 0)
        begin
            failures++;
            if (failures <= 10)
            begin
                $display("%0t: unexpected result alive %0b row %0d col %0d last %0b",
                         $time, next_alive, cell_row, cell_col, last_cell);
            end
        end
        else
        begin
            want = pending_updates.pop_front();
            if (next_alive !== want.alive || cell_row !== want.row ||
                cell_col !== want.col || last_cell !== want.last)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display({"%0t: mismatch expected alive %0b row %0d col %0d last %0b,",
                              " got alive %0b row %0d col %0d last %0b"},
                             $time, want.alive, want.row, want.col, want.last,
                             next_alive, cell_row, cell_col, last_cell);
                end
            end
        end
    endtask

    // monitor: everything is sampled at the rising edge, inputs having settled
    // at the falling edge before it
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_took <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                apply_size_write(cfg_index, cfg_data);
            end
            if (in_valid && !in_stall)
            begin
                step_generation(cell_alive);
            end
            // tells the driver at the next falling edge that its item went in
            in_took <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                check_update();
            end
        end
    end

    // driver: offers the queued cells, with random gaps and calm stretches;
    // an offered cell stays put until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_took)
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (cells_to_send.size() > 0)
            begin
                in_valid <= 1'b1;
                cell_alive <= cells_to_send.pop_front();
                if (send_calm > 0)
                begin
                    send_calm--;
                end
                else
                begin
                    send_gap = pick_idle_length();
                    if ($urandom_range(0, 199) == 0)
                    begin
                        send_calm = $urandom_range(100, 300);
                    end
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, calm stretches, and once a long hold-off while
    // the sender keeps going so that the block backs up into its input
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (!hold_done && results_seen >= HOLD_AFTER &&
                cells_to_send.size() > HOLD_BACKLOG)
            begin
                hold_done = 1'b1;
                recv_stall_left = HOLD_CYCLES;
            end
            if (recv_stall_left > 0)
            begin
                recv_stall_left--;
                out_stall <= 1'b1;
            end
            else if (recv_calm > 0)
            begin
                recv_calm--;
                out_stall <= 1'b0;
            end
            else
            begin
                recv_stall_left = pick_idle_length();
                if (recv_stall_left > 0)
                begin
                    recv_stall_left--;
                    out_stall <= 1'b1;
                end
                else
                begin
                    out_stall <= 1'b0;
                    if ($urandom_range(0, 199) == 0)
                    begin
                        recv_calm = $urandom_range(100, 300);
                    end
                end
            end
        end
    end

    // watchdog on handshakes of any kind
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // register write, one cycle of write enable
    task automatic write_register(input logic [lgs_pkg::CFG_IDX_W-1:0] idx,
                                  input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= lgs_pkg::CFG_W'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // queue random cells with the given chance of a live one, in percent
    task automatic queue_cells(input int unsigned count, input int unsigned density);
        repeat (count)
        begin
            cells_to_send.push_back($urandom_range(0, 99) < density);
        end
    endtask

    // wait until every cell is in and every update is out, then let the
    // pipeline empty of border cells, which leave no result behind; the queue
    // and valid are looked at on the rising edge, where the driver has settled
    task automatic wait_for_drain();
        @(posedge clk);
        while (cells_to_send.size() != 0 || in_valid || pending_updates.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // small board, one to three passes and then a part pass cut short by the
    // next phase's register write
    task automatic run_random_phase();
        int unsigned rows_raw;
        int unsigned cols_raw;
        int unsigned roll;
        int unsigned area;
        int unsigned count;
        rows_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        cols_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
        roll = $urandom_range(0, 3);
        // a single write is only safe while the other size is already small
        if (roll == 0 && clamp_dim(size_cols) <= 12)
        begin
            write_register(lgs_pkg::REG_BOARD_ROWS, rows_raw);
        end
        else if (roll == 1 && clamp_dim(size_rows) <= 12)
        begin
            write_register(lgs_pkg::REG_BOARD_COLS, cols_raw);
        end
        else
        begin
            write_register(lgs_pkg::REG_BOARD_ROWS, rows_raw);
            write_register(lgs_pkg::REG_BOARD_COLS, cols_raw);
        end
        area = clamp_dim(size_rows) * clamp_dim(size_cols);
        count = $urandom_range(1, 3) * area + $urandom_range(0, area - 1);
        queue_cells(count, 10 + 15 * $urandom_range(0, 4));
        random_cells += count;
        wait_for_drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // a few cells on the reset-size board: all in row 0, so no result, and
        // the write that follows must restart the scan mid row
        cells_to_send.push_back(1'b1);
        cells_to_send.push_back(1'b0);
        cells_to_send.push_back(1'b1);
        cells_to_send.push_back(1'b1);
        wait_for_drain();

        // sizes below the minimum act as 3 by 3: one interior cell per pass
        write_register(lgs_pkg::REG_BOARD_ROWS, 0);
        write_register(lgs_pkg::REG_BOARD_COLS, 2);
        // first pass all alive: the centre dies of overcrowding with 8 live
        // neighbours, and it is the last cell of the board
        repeat (9) cells_to_send.push_back(1'b1);
        // second pass after the wrap: a dead centre with exactly three live
        // neighbours, all of them on the border, is born
        cells_to_send.push_back(1'b1);
        cells_to_send.push_back(1'b1);
        cells_to_send.push_back(1'b0);
        cells_to_send.push_back(1'b0);
        cells_to_send.push_back(1'b0);
        cells_to_send.push_back(1'b0);
        cells_to_send.push_back(1'b1);
        cells_to_send.push_back(1'b0);
        cells_to_send.push_back(1'b0);
        wait_for_drain();

        while (random_cells < RANDOM_TOTAL)
        begin
            run_random_phase();
        end

        if (failures == 0 && pending_updates.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> life_generation_stencil.f
hw/rtl/lgs_pkg.sv
hw/rtl/lgs_cfg.sv
hw/rtl/lgs_line_store.sv
hw/rtl/lgs_cell_eval.sv
hw/rtl/life_generation_stencil.sv
tb/testbench.sv
